FILE: sv/salts_pkg.sv
// Shared constants and codes of the set-associative LRU tag store.
package salts_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int SETS_DEF     = 256;
  localparam int WAYS_DEF     = 8;
  localparam int AGE_BITS_DEF = 16;

  // Fixed field widths of the ports
  localparam int TAG_W     = 32;
  localparam int SET_IDX_W = 8;
  localparam int WAY_W     = 3;
  localparam int CFG_W     = 4;

  // Reset value of the ways-in-use register
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd8;

  // Operation codes
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

endpackage

FILE: sv/set_assoc_lru_tag_store_core.sv
// Tag directory of a set-associative cache with age-based LRU replacement.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction: op_i
// (lookup or insert), set_index_i and tag_i. Output channel (out_valid_o /
// out_ready_i) returns one result per transaction: hit_o, way_o, evicted_o.
// Config channel (cfg_valid_i / cfg_ready_o) writes ways_in_use; it is always
// ready and must only be used while no transaction is in flight.
// Each set is one row of a single-port-style memory with a registered read.
// The row is read at the accepting edge, then modified and written back in
// the ST_RMW state once the output register is free, when the result is
// registered as well. The read-modify-write of the set row means only one
// transaction is in the row pipeline at a time, until its write-back.
// The output register decouples the sides: a new transaction is accepted
// while a result waits; if the receiver stalls, the next write-back holds
// until the output register frees up.
// After reset, a clearing pass writes empty rows to all SETS rows, one per
// cycle with in_ready_o low; config writes are taken meanwhile.
module set_assoc_lru_tag_store_core #(
  parameter int SETS     = salts_pkg::SETS_DEF,
  parameter int WAYS     = salts_pkg::WAYS_DEF,
  parameter int AGE_BITS = salts_pkg::AGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [salts_pkg::CFG_W-1:0]     cfg_ways_in_use_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [salts_pkg::SET_IDX_W-1:0] set_index_i,
  input  logic [salts_pkg::TAG_W-1:0]     tag_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [salts_pkg::WAY_W-1:0]     way_o,
  output logic                            evicted_o
);

  localparam int TagW    = salts_pkg::TAG_W;
  localparam int CfgW    = salts_pkg::CFG_W;
  localparam int WayW    = salts_pkg::WAY_W;
  localparam int IdxW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WayIdxW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CntW    = $clog2(WAYS + 1);
  localparam int SumW    = AGE_BITS + CntW;
  localparam int RawSets = 2 ** salts_pkg::SET_IDX_W;

  localparam logic [AGE_BITS-1:0] AgeMax  = '1;
  localparam logic [IdxW-1:0]     LastRow = IdxW'(SETS - 1);

  typedef struct packed {
    logic                valid;
    logic [TagW-1:0]     tag;
    logic [AGE_BITS-1:0] age;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RMW   = 3'b100
  } state_e;

  // Saturating age increment
  function automatic logic [AGE_BITS-1:0] sat_add(logic [AGE_BITS-1:0] a,
                                                  logic [CntW-1:0] b);
    logic [SumW-1:0] sum;
    sum = {{CntW{1'b0}}, a} + SumW'(b);
    return (sum > {{CntW{1'b0}}, AgeMax}) ? AgeMax : sum[AGE_BITS-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [IdxW-1:0]      clr_q;
  logic [CfgW-1:0]      ways_cfg_q;
  logic                 op_q;
  logic [TagW-1:0]      tag_q;
  logic [IdxW-1:0]      row_idx_q;
  row_t                 mem_q [SETS];
  row_t                 rdata_q;
  logic                 out_valid_q;
  logic                 hit_q;
  logic [WayW-1:0]      way_q;
  logic                 evicted_q;

  logic [IdxW-1:0]      set_wrap [RawSets];
  logic                 in_acc;
  logic                 out_free;
  logic                 mem_re;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  row_t                 mem_wdata;
  logic [CfgW-1:0]      n_active;
  logic [WAYS-1:0]      act;
  logic [WAYS-1:0]      vld;
  logic [WAYS-1:0]      match;
  logic [CntW-1:0]      match_cnt;
  logic [CntW-1:0]      after_cnt [WAYS];
  logic [AGE_BITS-1:0]  aged [WAYS];
  row_t                 new_row;
  logic [WayIdxW-1:0]   pick;
  logic                 found_empty;
  logic [AGE_BITS-1:0]  best;
  logic                 res_hit;
  logic                 res_evicted;

  // Set index wraps modulo SETS through a constant table
  for (genvar g = 0; g < RawSets; g++) begin : g_wrap
    assign set_wrap[g] = IdxW'(g % SETS);
  end

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign mem_re      = in_acc;

  // Active way count, clamped to 1..WAYS
  always_comb begin
    if (ways_cfg_q == '0) begin
      n_active = CfgW'(1);
    end else if (32'(ways_cfg_q) > WAYS) begin
      n_active = CfgW'(WAYS);
    end else begin
      n_active = ways_cfg_q;
    end
  end

  // Match vector and per-way match counts
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      act[w]   = (w < 32'(n_active));
      vld[w]   = act[w] && rdata_q[w].valid;
      match[w] = vld[w] && (rdata_q[w].tag == tag_q);
      aged[w]  = vld[w] ? sat_add(rdata_q[w].age, CntW'(1)) : rdata_q[w].age;
    end
    match_cnt = '0;
    for (int w = 0; w < WAYS; w++) begin
      match_cnt = match_cnt + CntW'(match[w]);
    end
    // matches that come later in way order than way w
    for (int w = 0; w < WAYS; w++) begin
      after_cnt[w] = '0;
      for (int j = 0; j < WAYS; j++) begin
        if (j > w) begin
          after_cnt[w] = after_cnt[w] + CntW'(match[j]);
        end
      end
    end
  end

  // Row update and result for lookup or insert
  always_comb begin
    new_row     = rdata_q;
    pick        = '0;
    found_empty = 1'b0;
    best        = '0;
    res_hit     = 1'b0;
    res_evicted = 1'b0;
    case (op_q)
      salts_pkg::OP_LOOKUP: begin
        // each match ages the set once, then clears its own age
        for (int w = 0; w < WAYS; w++) begin
          if (match[w]) begin
            new_row[w].age = sat_add('0, after_cnt[w]);
            pick           = WayIdxW'(w);
          end else if (vld[w]) begin
            new_row[w].age = sat_add(rdata_q[w].age, match_cnt);
          end
        end
        res_hit = (match_cnt != '0);
      end
      salts_pkg::OP_INSERT: begin
        for (int w = 0; w < WAYS; w++) begin
          new_row[w].age = aged[w];
        end
        // first empty active way
        for (int w = WAYS - 1; w >= 0; w--) begin
          if (act[w] && !rdata_q[w].valid) begin
            pick        = WayIdxW'(w);
            found_empty = 1'b1;
          end
        end
        // otherwise the oldest active way, last one on a tie
        if (!found_empty) begin
          for (int w = 0; w < WAYS; w++) begin
            if (act[w] && (aged[w] >= best)) begin
              best = aged[w];
              pick = WayIdxW'(w);
            end
          end
          res_evicted = 1'b1;
        end
        new_row[pick].valid = 1'b1;
        new_row[pick].tag   = tag_q;
        new_row[pick].age   = '0;
      end
      default: begin
        new_row = rdata_q;
      end
    endcase
  end

  // Sequencer: clearing pass, accept, read-modify-write
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = row_idx_q;
    mem_wdata = new_row;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LastRow) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ways_cfg_q  <= salts_pkg::WAYS_IN_USE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ways_cfg_q <= cfg_ways_in_use_i;
      end
      if (state_q == ST_RMW && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= op_i;
      tag_q     <= tag_i;
      row_idx_q <= set_wrap[set_index_i];
    end
    if (state_q == ST_RMW && out_free) begin
      hit_q     <= res_hit;
      way_q     <= WayW'(pick);
      evicted_q <= res_evicted;
    end
  end

  // Set memory: one row per set, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[set_wrap[set_index_i]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = way_q;
  assign evicted_o   = evicted_q;

`ifndef SYNTHESIS
  // A result appears only after a write-back
  a_result_after_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RMW))
    else $error("result raised without a read-modify-write");

  // Accepted transaction goes to the write-back step next
  a_accept_to_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RMW))
    else $error("accepted transaction not processed");

  // Read and write never collide on the memory
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction reported together");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the set-associative LRU tag store core.
module testbench;

  localparam int SETS           = salts_pkg::SETS_DEF;
  localparam int WAYS           = salts_pkg::WAYS_DEF;
  localparam int AGE_BITS       = salts_pkg::AGE_BITS_DEF;
  localparam int SET_IDX_W      = salts_pkg::SET_IDX_W;
  localparam int TAG_W          = salts_pkg::TAG_W;
  localparam int WAY_W          = salts_pkg::WAY_W;
  localparam int CFG_W          = salts_pkg::CFG_W;
  localparam int IDLE_PCT       = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SOAK_LOOKUPS   = 40;

  typedef struct {
    salts_pkg::op_e       op;
    logic [SET_IDX_W-1:0] set_idx;
    logic [TAG_W-1:0]     tag;
  } tag_access_t;

  typedef struct {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
  } tag_result_t;

  // DUT inputs, known from time zero
  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_valid_i       = 1'b0;
  logic [CFG_W-1:0]     cfg_ways_in_use_i = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 op_i              = 1'b0;
  logic [SET_IDX_W-1:0] set_index_i       = '0;
  logic [TAG_W-1:0]     tag_i             = '0;
  logic                 out_ready_i       = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 hit_o;
  logic [WAY_W-1:0]     way_o;
  logic                 evicted_o;

  // Directory shadow used for prediction
  bit                  dir_valid [SETS][WAYS];
  logic [TAG_W-1:0]    dir_tag   [SETS][WAYS];
  logic [AGE_BITS-1:0] dir_age   [SETS][WAYS];
  logic [CFG_W-1:0]    ways_cfg = salts_pkg::WAYS_IN_USE_RST;

  tag_access_t access_q[$];
  tag_result_t result_q[$];

  bit                   steady_flow    = 1'b0;
  int                   mismatch_count = 0;
  int                   access_count   = 0;
  int                   result_count   = 0;
  int                   cfg_count      = 0;
  int                   hit_count      = 0;
  int                   evict_count    = 0;
  int                   stall_cycles   = 0;
  logic [SET_IDX_W-1:0] hot_sets [4];
  logic [TAG_W-1:0]     tag_pool [16];

  set_assoc_lru_tag_store_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_ways_in_use_i (cfg_ways_in_use_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .set_index_i       (set_index_i),
    .tag_i             (tag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .way_o             (way_o),
    .evicted_o         (evicted_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Zero and out-of-range register values clamp to the legal way count
  function automatic int active_ways();
    if (ways_cfg == '0) return 1;
    if (int'(ways_cfg) > WAYS) return WAYS;
    return int'(ways_cfg);
  endfunction

  // Saturating age increment of every valid active way
  function automatic void age_ways(int s, int n);
    int w;
    for (w = 0; w < n; w++) begin
      if (dir_valid[s][w] && dir_age[s][w] != '1) dir_age[s][w]++;
    end
  endfunction

  // Expected outcome of one access; updates the directory shadow
  function automatic tag_result_t apply_access(tag_access_t a);
    tag_result_t   r;
    int            n;
    int            s;
    int            w;
    bit            found;
    logic [AGE_BITS-1:0] best;
    r     = '{hit: 1'b0, way: '0, evicted: 1'b0};
    n     = active_ways();
    s     = int'(a.set_idx) % SETS;
    found = 1'b0;
    if (a.op == salts_pkg::OP_LOOKUP) begin
      // every matching way ages the set, the last match is reported
      for (w = 0; w < n; w++) begin
        if (dir_valid[s][w] && dir_tag[s][w] == a.tag) begin
          age_ways(s, n);
          dir_age[s][w] = '0;
          r.hit = 1'b1;
          r.way = WAY_W'(w);
        end
      end
    end else begin
      age_ways(s, n);
      for (w = 0; w < n; w++) begin
        if (!found && !dir_valid[s][w]) begin
          r.way = WAY_W'(w);
          found = 1'b1;
        end
      end
      // full set: oldest way goes, last one on a tie
      if (!found) begin
        best = '0;
        for (w = 0; w < n; w++) begin
          if (dir_age[s][w] >= best) begin
            best  = dir_age[s][w];
            r.way = WAY_W'(w);
          end
        end
        r.evicted = 1'b1;
      end
      dir_valid[s][r.way] = 1'b1;
      dir_tag[s][r.way]   = a.tag;
      dir_age[s][r.way]   = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic push_access(salts_pkg::op_e op, logic [SET_IDX_W-1:0] s,
                             logic [TAG_W-1:0] t);
    tag_access_t a;
    a.op      = op;
    a.set_idx = s;
    a.tag     = t;
    access_q.push_back(a);
  endtask

  // Random accesses, mostly to a few hot sets with a small tag pool
  task automatic queue_random(int count);
    tag_access_t a;
    int          k;
    int          pick;
    for (k = 0; k < 16; k++) tag_pool[k] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_IDX_W'($urandom);
    hot_sets[3] = SET_IDX_W'($urandom);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      a.op = salts_pkg::op_e'($urandom_range(1));
      if (pick < 75) begin
        a.set_idx = hot_sets[$urandom_range(3)];
        a.tag     = tag_pool[$urandom_range(15)];
      end else if (pick < 90) begin
        a.set_idx = SET_IDX_W'($urandom);
        a.tag     = tag_pool[$urandom_range(15)];
      end else begin
        a.set_idx = SET_IDX_W'($urandom);
        a.tag     = $urandom;
      end
      access_q.push_back(a);
    end
  endtask

  // Wait until all accesses are issued and answered, then let the pipe settle;
  // sampled mid-cycle so the driver's updates of the same edge are seen
  task automatic drain();
    do @(negedge clk_i);
    while (access_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ways(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_ways_in_use_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ways_cfg = v;
    cfg_count++;
  endtask

  // Input driver: issues queued accesses and predicts each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    tag_access_t a;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        a.op      = salts_pkg::op_e'(op_i);
        a.set_idx = set_index_i;
        a.tag     = tag_i;
        result_q.push_back(apply_access(a));
        access_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (access_q.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          a = access_q.pop_front();
          in_valid_i  <= 1'b1;
          op_i        <= a.op;
          set_index_i <= a.set_idx;
          tag_i       <= a.tag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    tag_result_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (result_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: hit=%0b way=%0d evicted=%0b",
                                  hit_o, way_o, evicted_o));
        end else begin
          e = result_q.pop_front();
          if (e.hit) hit_count++;
          if (e.evicted) evict_count++;
          if (hit_o !== e.hit)
            flag_mismatch($sformatf("result %0d hit: got %b want %b",
                                    result_count, hit_o, e.hit));
          if (way_o !== e.way)
            flag_mismatch($sformatf("result %0d way: got %0d want %0d",
                                    result_count, way_o, e.way));
          if (evicted_o !== e.evicted)
            flag_mismatch($sformatf("result %0d evicted: got %b want %b",
                                    result_count, evicted_o, e.evicted));
        end
      end
      out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cycles);
      $display("set_assoc_lru_tag_store_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    logic [TAG_W-1:0] soak_tag;
    int               k;
    foreach (dir_valid[s, w]) begin
      dir_valid[s][w] = 1'b0;
      dir_tag[s][w]   = '0;
      dir_age[s][w]   = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Written while the clear pass runs; above WAYS clamps to all ways
    write_ways(4'd15);
    // Empty ways never match, not even an all-ones tag
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'hFFFF_FFFF);
    push_access(salts_pkg::OP_LOOKUP, 8'd255, 32'h0000_0000);
    // Fill set 0, then force an LRU eviction
    for (k = 0; k < WAYS; k++) push_access(salts_pkg::OP_INSERT, 8'd0, 32'h10 + k);
    push_access(salts_pkg::OP_INSERT, 8'd0, 32'hFFFF_FFFF);
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'hFFFF_FFFF);
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'h11);
    // Duplicate tags: last matching way is reported
    push_access(salts_pkg::OP_INSERT, 8'd255, 32'h0);
    push_access(salts_pkg::OP_INSERT, 8'd255, 32'h0);
    push_access(salts_pkg::OP_LOOKUP, 8'd255, 32'h0);
    push_access(salts_pkg::OP_INSERT, 8'd255, 32'hA5A5_A5A5);
    push_access(salts_pkg::OP_LOOKUP, 8'd255, 32'h5A5A_5A5A);
    push_access(salts_pkg::OP_INSERT, 8'd0, 32'h8000_0000);
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'h10);
    drain();

    // Zero acts as a single way; other ways keep their contents untouched
    write_ways(4'd0);
    push_access(salts_pkg::OP_INSERT, 8'd0, 32'h1234_5678);
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'h12);
    push_access(salts_pkg::OP_LOOKUP, 8'd0, 32'h1234_5678);
    queue_random(200);
    drain();

    write_ways(4'd1);
    queue_random(250);
    drain();

    // Back-to-back traffic with no idling on either side
    write_ways(4'd8);
    steady_flow = 1'b1;
    queue_random(300);
    drain();
    steady_flow = 1'b0;

    write_ways(4'd4);
    queue_random(250);
    drain();

    write_ways(4'($urandom_range(15, 9)));
    queue_random(250);
    drain();

    write_ways(4'($urandom_range(7, 2)));
    queue_random(250);
    drain();

    write_ways(4'd8);
    queue_random(200);
    drain();

    // LRU order: keep hitting one way so the other two age in step,
    // then insert twice so the two oldest ways are evicted in turn
    write_ways(4'd3);
    for (k = 0; k < 3; k++) push_access(salts_pkg::OP_INSERT, 8'd77, 32'hC0DE_0000 + k);
    soak_tag = 32'hC0DE_0002;
    for (k = 0; k < SOAK_LOOKUPS; k++) push_access(salts_pkg::OP_LOOKUP, 8'd77, soak_tag);
    push_access(salts_pkg::OP_INSERT, 8'd77, 32'hC0DE_0100);
    push_access(salts_pkg::OP_INSERT, 8'd77, 32'hC0DE_0101);
    for (k = 0; k < 3; k++) push_access(salts_pkg::OP_LOOKUP, 8'd77, 32'hC0DE_0000 + k);
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d accesses, %0d results, %0d ways-in-use writes",
             access_count, result_count, cfg_count);
    $display("  %0d lookup hits, %0d LRU evictions, %0d mismatches",
             hit_count, evict_count, mismatch_count);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("set_assoc_lru_tag_store_core regression: pass");
    end else begin
      $display("set_assoc_lru_tag_store_core regression: fail");
    end
    $finish;
  end

endmodule
